### hdl/chkt_pkg.sv
// Package: shared types, codes and constants of the chained hash key table.
`timescale 1ns / 1ps
`default_nettype none
package chkt_pkg;

	// Default sizes
	localparam int BUCKETS_DEF = 1024;
	localparam int NODES_DEF   = 4096;

	// Width of the bucket field carried in the queue (covers the largest table)
	localparam int BKT_FIELD_W = 16;

	// Mixer constants
	localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
	localparam int MIX_S1 = 30;
	localparam int MIX_S2 = 27;
	localparam int MIX_S3 = 31;

	// Request kinds
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_FIND   = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] key;
		logic [31:0] value_in;
	} chkt_req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] value_out;
		logic        pool_full;
	} chkt_rsp_t;

	typedef struct packed {
		chkt_req_t              req;
		logic [BKT_FIELD_W-1:0] bucket;
	} chkt_qent_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_HASH,
		F_MOD,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_HEAD,
		B_WALK,
		B_NODE,
		B_DECIDE,
		B_ALLOC,
		B_REM1
	} back_state_t;

endpackage
`default_nettype wire

### hdl/chained_hash_key_table_top.sv
// Top level of the chained hash key table: front, queue and back end.
//
//  channel   ports               handshake
//  request   start, busy, req    taken when start is high and busy low
//  result    done, rsp           done high for one cycle per result
//
// Front: hashes the key, reduces it to a bucket (by remainder when BUCKETS is not a power
// of two), then queues the item, waiting while the queue is full.
// Back: reads the bucket head, walks the chain until the key matches or the chain ends,
// decides, then writes the table for an insert or remove that updates it; an unused kind skips
// to deciding. done is registered from the finish. After reset a clearing pass empties the
// bucket heads; busy is high during it. The receiver cannot stall; results leave in order.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_key_table_top
	import chkt_pkg::*;
#(
	parameter int BUCKETS = BUCKETS_DEF,
	parameter int NODES   = NODES_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire chkt_req_t req,
	output logic           done,
	output chkt_rsp_t      rsp
);

	logic       front_busy;
	logic       clearing;
	logic       push;
	chkt_qent_t push_ent;
	logic       q_full;
	logic       q_empty;
	logic       q_pop;
	chkt_qent_t head_ent;

	// Hold requests off while the front works or the heads are cleared
	assign busy = front_busy | clearing;

	chkt_front #(.BUCKETS(BUCKETS)) u_front (
		.clk(clk), .arst_n(arst_n), .take(start && !busy), .req(req),
		.busy(front_busy), .push(push), .push_ent(push_ent), .q_full(q_full)
	);

	chkt_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_ent(push_ent),
		.full(q_full), .pop(q_pop), .empty(q_empty), .head_ent(head_ent)
	);

	chkt_back #(.BUCKETS(BUCKETS), .NODES(NODES)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(!q_empty), .q_ent(head_ent),
		.q_pop(q_pop), .clearing(clearing), .done(done), .rsp(rsp)
	);

endmodule
`default_nettype wire

### hdl/chkt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module chkt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### hdl/chkt_fifo.sv
// Two-entry queue between the hashing front and the table back end.
`timescale 1ns / 1ps
`default_nettype none
module chkt_fifo
	import chkt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire chkt_qent_t push_ent,
	output logic            full,
	input  wire logic       pop,
	output logic            empty,
	output chkt_qent_t      head_ent
);

	chkt_qent_t ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign head_ent = ent_q[rp_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wp_q] <= push_ent;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wp_q <= ~wp_q;
			end
			if (pop && !empty) begin
				rp_q <= ~rp_q;
			end
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/chkt_front.sv
// Front end: accepts requests, hashes the key and reduces it to a bucket.
`timescale 1ns / 1ps
`default_nettype none
module chkt_front
	import chkt_pkg::*;
#(
	parameter int BUCKETS = BUCKETS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      take,
	input  wire chkt_req_t req,
	output logic           busy,
	output logic           push,
	output chkt_qent_t     push_ent,
	input  wire logic      q_full
);

	localparam int BW = $clog2(BUCKETS);
	localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
	// Reciprocal of the bucket count, scaled by 2^32
	localparam logic [31:0] MU = 32'(64'h1_0000_0000 / 64'(BUCKETS));
	localparam logic [31:0] BK = 32'(BUCKETS);

	front_state_t state_q, state_d;
	chkt_req_t    req_q;
	logic [1:0]   phase_q;
	logic         round_q;
	logic [63:0]  a_q;
	logic [63:0]  prod_q;
	logic [63:0]  acc_q;
	logic [63:0]  h_q;
	logic [BW-1:0] rem_q;
	logic [2:0]   cnt_q;
	logic [BW-1:0] bkt_q;

	logic [63:0]  c_sel;
	logic [31:0]  mul_a;
	logic [31:0]  mul_b;
	logic [63:0]  mul_p;
	logic [63:0]  y;
	logic [63:0]  h_new;
	logic [31:0]  mod_n;
	logic [31:0]  mod_qb;
	logic [31:0]  mod_r;
	logic [31:0]  mod_rf;

	// Select one 32x32 partial product per phase, or the quotient estimate
	always_comb begin
		c_sel = round_q ? MIX_C2 : MIX_C1;
		case (phase_q)
			2'd0: begin
				mul_a = a_q[31:0];
				mul_b = c_sel[31:0];
			end
			2'd1: begin
				mul_a = a_q[31:0];
				mul_b = c_sel[63:32];
			end
			2'd2: begin
				mul_a = a_q[63:32];
				mul_b = c_sel[31:0];
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
		if (state_q == F_MOD) begin
			mul_a = mod_n;
			mul_b = MU;
		end
		mul_p = {32'd0, mul_a} * {32'd0, mul_b};
		y     = acc_q + {prod_q[31:0], 32'd0};
		h_new = y ^ (y >> MIX_S3);
	end

	// One remainder step per 16-bit digit, MSB first: estimate the quotient
	// by the reciprocal, which is low by at most one, then correct once
	always_comb begin
		mod_n  = {16'(rem_q), h_q[63:48]};
		mod_qb = {16'd0, prod_q[47:32]} * {16'd0, BK[15:0]};
		mod_r  = mod_n - mod_qb;
		mod_rf = (mod_r >= BK) ? (mod_r - BK) : mod_r;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (take) state_d = F_HASH;
			end
			F_HASH: begin
				if (phase_q == 2'd3 && round_q) state_d = POW2 ? F_PUSH : F_MOD;
			end
			F_MOD: begin
				if (cnt_q == 3'd7) state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!q_full) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		busy = (state_q != F_IDLE);
		push = (state_q == F_PUSH);
		push_ent.req    = req_q;
		push_ent.bucket = BKT_FIELD_W'(bkt_q);
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hash datapath: four phases a round, a register after every product
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (take) begin
					req_q   <= req;
					a_q     <= req.key ^ (req.key >> MIX_S1);
					round_q <= 1'b0;
					phase_q <= 2'd0;
				end
			end
			F_HASH: begin
				prod_q  <= mul_p;
				phase_q <= phase_q + 2'd1;
				case (phase_q)
					2'd1: acc_q <= prod_q;
					2'd2: acc_q <= acc_q + {prod_q[31:0], 32'd0};
					default: acc_q <= acc_q;
				endcase
				if (phase_q == 2'd3) begin
					if (!round_q) begin
						a_q     <= y ^ (y >> MIX_S2);
						round_q <= 1'b1;
					end else begin
						h_q   <= h_new;
						bkt_q <= h_new[BW-1:0];
						rem_q <= '0;
						cnt_q <= 3'd0;
					end
				end
			end
			F_MOD: begin
				// Even cycles register the estimate, odd cycles take the digit in
				cnt_q <= cnt_q + 3'd1;
				if (!cnt_q[0]) begin
					prod_q <= mul_p;
				end else begin
					rem_q <= mod_rf[BW-1:0];
					h_q   <= {h_q[47:0], 16'd0};
				end
				if (cnt_q == 3'd7) bkt_q <= mod_rf[BW-1:0];
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

endmodule
`default_nettype wire

### hdl/chkt_back.sv
// Back end: walks bucket chains and applies insert, find and remove.
`timescale 1ns / 1ps
`default_nettype none
module chkt_back
	import chkt_pkg::*;
#(
	parameter int BUCKETS = BUCKETS_DEF,
	parameter int NODES   = NODES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	input  wire chkt_qent_t q_ent,
	output logic            q_pop,
	output logic            clearing,
	output logic            done,
	output chkt_rsp_t       rsp
);

	localparam int BW = $clog2(BUCKETS);
	localparam int NW = $clog2(NODES);
	localparam int LW = $clog2(NODES + 1);

	back_state_t state_q, state_d;
	chkt_req_t   req_q;
	logic [BW-1:0] bkt_q;
	logic [BW-1:0] clr_q;
	logic [LW-1:0] head_q;
	logic [LW-1:0] cur_q;
	logic [LW-1:0] cur_next_q;
	logic [NW-1:0] prev_q;
	logic          prev_valid_q;
	logic [LW-1:0] steps_q;
	logic          found_q;
	logic [31:0]   found_val_q;
	logic [LW-1:0] free_head_q;
	logic [LW-1:0] fresh_q;
	logic [NW-1:0] n_q;
	logic          alloc_free_q;

	// Memory ports
	logic          head_we;
	logic [BW-1:0] head_waddr;
	logic [LW-1:0] head_wdata;
	logic [LW-1:0] head_rdata;
	logic          node_we;
	logic          next_we;
	logic [NW-1:0] next_waddr;
	logic [LW-1:0] next_wdata;
	logic [NW-1:0] node_raddr;
	logic [63:0]   key_rdata;
	logic [31:0]   val_rdata;
	logic [LW-1:0] next_rdata;

	logic          cur_ok;
	logic [NW-1:0] cur_idx;
	logic          free_ok;
	logic [NW-1:0] free_idx;
	logic          fresh_ok;
	logic          fin;
	chkt_rsp_t     fin_rsp;

	chkt_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(q_ent.bucket[BW-1:0]), .rdata(head_rdata)
	);
	chkt_ram #(.WIDTH(64), .DEPTH(NODES)) u_key (
		.clk(clk), .we(node_we), .waddr(n_q), .wdata(req_q.key),
		.raddr(node_raddr), .rdata(key_rdata)
	);
	chkt_ram #(.WIDTH(32), .DEPTH(NODES)) u_val (
		.clk(clk), .we(node_we), .waddr(n_q), .wdata(req_q.value_in),
		.raddr(node_raddr), .rdata(val_rdata)
	);
	chkt_ram #(.WIDTH(LW), .DEPTH(NODES)) u_next (
		.clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
		.raddr(node_raddr), .rdata(next_rdata)
	);

	// Decode links (index + 1, zero for none)
	always_comb begin
		cur_ok   = (cur_q != '0) && (cur_q <= LW'(NODES));
		cur_idx  = NW'(cur_q - LW'(1));
		free_ok  = (free_head_q != '0) && (free_head_q <= LW'(NODES));
		free_idx = NW'(free_head_q - LW'(1));
		fresh_ok = (fresh_q < LW'(NODES));
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_CLEAR: begin
				if (clr_q == BW'(BUCKETS - 1)) state_d = B_IDLE;
			end
			B_IDLE: begin
				if (q_valid) begin
					state_d = (q_ent.req.kind == KIND_INSERT ||
						q_ent.req.kind == KIND_FIND ||
						q_ent.req.kind == KIND_REMOVE) ? B_HEAD : B_DECIDE;
				end
			end
			B_HEAD: state_d = B_WALK;
			B_WALK: begin
				state_d = (cur_ok && steps_q < LW'(NODES)) ? B_NODE : B_DECIDE;
			end
			B_NODE: begin
				state_d = (key_rdata == req_q.key) ? B_DECIDE : B_WALK;
			end
			B_DECIDE: begin
				case (req_q.kind)
					KIND_INSERT: begin
						if (found_q || !(free_ok || fresh_ok)) state_d = B_IDLE;
						else state_d = B_ALLOC;
					end
					KIND_REMOVE: state_d = found_q ? B_REM1 : B_IDLE;
					default:     state_d = B_IDLE;
				endcase
			end
			B_ALLOC: state_d = B_IDLE;
			B_REM1:  state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// Outputs: memory controls and the finished result
	always_comb begin
		q_pop      = (state_q == B_IDLE) && q_valid;
		clearing   = (state_q == B_CLEAR);
		head_we    = 1'b0;
		head_waddr = bkt_q;
		head_wdata = '0;
		node_we    = 1'b0;
		next_we    = 1'b0;
		next_waddr = n_q;
		next_wdata = head_q;
		node_raddr = cur_idx;
		fin        = 1'b0;
		fin_rsp    = '0;
		case (state_q)
			B_CLEAR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
			end
			B_DECIDE: begin
				node_raddr = free_idx;
				case (req_q.kind)
					KIND_INSERT: begin
						if (found_q) begin
							fin               = 1'b1;
							fin_rsp.hit       = 1'b1;
							fin_rsp.value_out = found_val_q;
						end else if (!(free_ok || fresh_ok)) begin
							fin               = 1'b1;
							fin_rsp.pool_full = 1'b1;
						end
					end
					KIND_FIND: begin
						fin               = 1'b1;
						fin_rsp.hit       = found_q;
						fin_rsp.value_out = found_q ? found_val_q : 32'd0;
					end
					KIND_REMOVE: begin
						// A found remove finishes after its two link updates
						if (!found_q) begin
							fin = 1'b1;
						end else if (prev_valid_q) begin
							next_we    = 1'b1;
							next_waddr = prev_q;
							next_wdata = cur_next_q;
						end else begin
							head_we    = 1'b1;
							head_wdata = cur_next_q;
						end
					end
					default: fin = 1'b1;
				endcase
			end
			B_ALLOC: begin
				node_we           = 1'b1;
				next_we           = 1'b1;
				head_we           = 1'b1;
				head_wdata        = LW'(n_q) + LW'(1);
				fin               = 1'b1;
				fin_rsp.value_out = req_q.value_in;
			end
			B_REM1: begin
				next_we    = 1'b1;
				next_waddr = cur_idx;
				next_wdata = free_head_q;
				fin        = 1'b1;
				fin_rsp.hit = 1'b1;
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	// Hold control state and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			free_head_q <= '0;
			fresh_q     <= '0;
			done        <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= fin;
			if (state_q == B_CLEAR) clr_q <= clr_q + BW'(1);
			if (state_q == B_IDLE && q_valid) found_q <= 1'b0;
			if (state_q == B_NODE && key_rdata == req_q.key) found_q <= 1'b1;
			if (state_q == B_ALLOC) begin
				if (alloc_free_q) free_head_q <= next_rdata;
				else fresh_q <= fresh_q + LW'(1);
			end
			if (state_q == B_REM1) free_head_q <= cur_q;
			// Drop the found mark once a remove has finished
			if (state_q == B_REM1) found_q <= 1'b0;
		end
	end

	// Walk datapath
	always_ff @(posedge clk) begin
		if (fin) rsp <= fin_rsp;
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					req_q <= q_ent.req;
					bkt_q <= q_ent.bucket[BW-1:0];
				end
			end
			B_HEAD: begin
				head_q       <= head_rdata;
				cur_q        <= head_rdata;
				steps_q      <= '0;
				prev_valid_q <= 1'b0;
			end
			B_NODE: begin
				if (key_rdata == req_q.key) begin
					found_val_q <= val_rdata;
					cur_next_q  <= next_rdata;
				end else begin
					prev_q       <= cur_idx;
					prev_valid_q <= 1'b1;
					cur_q        <= next_rdata;
					steps_q      <= steps_q + LW'(1);
				end
			end
			B_DECIDE: begin
				alloc_free_q <= free_ok;
				n_q          <= free_ok ? free_idx : NW'(fresh_q);
			end
			default: begin
				bkt_q <= bkt_q;
			end
		endcase
	end

endmodule
`default_nettype wire
